[hw/rtl/stsi_pkg.sv]
// ----------------------------------------------------------------------------
// stsi_pkg
// Shared types and constants for the sorted table search/insert block.
// ----------------------------------------------------------------------------
package stsi_pkg;

   // Default number of table slots
   localparam int DEPTH_DEFAULT = 64;

   // Field widths of the transaction ports
   localparam int KEY_W = 32;
   localparam int OUT_W = 7;

   // Result outcome codes
   typedef enum logic [1:0] {
      OUTC_SWAPPED  = 2'd0,
      OUTC_LAST     = 2'd1,
      OUTC_INSERTED = 2'd2,
      OUTC_DROPPED  = 2'd3
   } outcome_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_SW_RD,
      ST_SW_WR,
      ST_SW_WR2,
      ST_SH_RD,
      ST_SH_WR,
      ST_INS,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/sorted_table_search_insert.sv]
// ----------------------------------------------------------------------------
// sorted_table_search_insert
// Binary search over a stored key table with swap-forward on a hit and
// ordered insertion on a miss.
// ----------------------------------------------------------------------------
// Each request transaction carries one signed 32-bit key and produces exactly
// one response transaction. The table lives in a single-port-write,
// single-port-read memory with registered read data, and one sequencer walks
// every step through it: each binary-search probe issues the address in
// ST_PROBE and compares the registered entry in ST_CMP, and a search that
// misses returns once more to ST_PROBE to find the range empty (at most
// log2(DEPTH)+1 probes). A hit on the last entry, or a miss on a full table,
// ends there; a hit elsewhere goes on to the swap with the successor; a
// miss moves the larger entries up one slot and then writes the key. The
// accept and the loading of the response register are steps of their own,
// and that last step waits for as long as the previous response is still
// unclaimed. The block takes a new request while the previous response is
// still waiting, but works on one key at a time.
// After reset the table is empty and no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_table_search_insert
   import stsi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [KEY_W-1:0] req_key,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_outcome,
   output logic [OUT_W-1:0]        rsp_position,
   output logic [OUT_W-1:0]        rsp_entries_now
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer and working registers
   state_type               state_ff, state_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]           lo_ff, lo_in;
   logic [CW-1:0]           hx_ff, hx_in;    // one past the high bound
   logic [IW-1:0]           mid_ff, mid_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   outcome_type             outc_ff, outc_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_outcome_ff, rsp_outcome_in;
   logic [OUT_W-1:0]        rsp_position_ff, rsp_position_in;
   logic [OUT_W-1:0]        rsp_entries_ff, rsp_entries_in;

   // Table memory
   logic signed [KEY_W-1:0] mem [DEPTH];
   logic signed [KEY_W-1:0] rdata_ff;
   logic                    mem_we;
   logic [IW-1:0]           mem_wa;
   logic signed [KEY_W-1:0] mem_wd;
   logic [IW-1:0]           mem_ra;

   // Midpoint of the live range: floor((lo + hi) / 2) with hi = hx - 1
   logic [CW:0]             mid_sum;
   logic [IW-1:0]           mid_calc;
   logic [CW+OUT_W-1:0]     pos_wide;
   logic [CW+OUT_W-1:0]     cnt_wide;
   logic [CW-1:0]           idx_dec;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hx_ff} - (CW+1)'(1);
   assign mid_calc = mid_sum[IW:1];
   assign idx_dec  = idx_ff - CW'(1);
   assign pos_wide = {{OUT_W{1'b0}}, pos_ff};
   assign cnt_wide = {{OUT_W{1'b0}}, count_ff};

   // Memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[mem_ra];
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hx_ff           <= hx_in;
      mid_ff          <= mid_in;
      idx_ff          <= idx_in;
      pos_ff          <= pos_in;
      outc_ff         <= outc_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_position_ff <= rsp_position_in;
      rsp_entries_ff  <= rsp_entries_in;
   end

   // Sequencer: next state, memory control and response loading
   always_comb begin
      state_in        = state_ff;
      key_in          = key_ff;
      lo_in           = lo_ff;
      hx_in           = hx_ff;
      mid_in          = mid_ff;
      idx_in          = idx_ff;
      count_in        = count_ff;
      pos_in          = pos_ff;
      outc_in         = outc_ff;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_position_in = rsp_position_ff;
      rsp_entries_in  = rsp_entries_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      mem_we          = 1'b0;
      mem_wa          = mid_ff;
      mem_wd          = key_ff;
      mem_ra          = mid_calc;
      req_ready       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in   = req_key;
               lo_in    = '0;
               hx_in    = count_ff;
               state_in = ST_PROBE;
            end
         end

         // Issue a probe read, or resolve a miss when the range is empty
         ST_PROBE: begin
            if (lo_ff < hx_ff) begin
               mid_in   = mid_calc;
               state_in = ST_CMP;
            end else begin
               pos_in = lo_ff;
               idx_in = count_ff;
               if (count_ff == CW'(DEPTH)) begin
                  outc_in  = OUTC_DROPPED;
                  state_in = ST_DONE;
               end else if (count_ff > lo_ff) begin
                  state_in = ST_SH_RD;
               end else begin
                  state_in = ST_INS;
               end
            end
         end

         // Compare the probed entry with the key
         ST_CMP: begin
            if (rdata_ff == key_ff) begin
               pos_in = CW'(mid_ff);
               if (CW'(mid_ff) == count_ff - CW'(1)) begin
                  outc_in  = OUTC_LAST;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SW_RD;
               end
            end else if (rdata_ff < key_ff) begin
               lo_in    = CW'(mid_ff) + CW'(1);
               state_in = ST_PROBE;
            end else begin
               hx_in    = CW'(mid_ff);
               state_in = ST_PROBE;
            end
         end

         // Swap the hit with its successor
         ST_SW_RD: begin
            mem_ra   = mid_ff + IW'(1);
            state_in = ST_SW_WR;
         end

         ST_SW_WR: begin
            mem_we   = 1'b1;
            mem_wa   = mid_ff;
            mem_wd   = rdata_ff;
            state_in = ST_SW_WR2;
         end

         ST_SW_WR2: begin
            mem_we   = 1'b1;
            mem_wa   = mid_ff + IW'(1);
            mem_wd   = key_ff;
            outc_in  = OUTC_SWAPPED;
            state_in = ST_DONE;
         end

         // Move entries up one slot, top first
         ST_SH_RD: begin
            mem_ra   = idx_dec[IW-1:0];
            state_in = ST_SH_WR;
         end

         ST_SH_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[IW-1:0];
            mem_wd = rdata_ff;
            idx_in = idx_dec;
            if (idx_dec > lo_ff) begin
               state_in = ST_SH_RD;
            end else begin
               state_in = ST_INS;
            end
         end

         ST_INS: begin
            mem_we   = 1'b1;
            mem_wa   = lo_ff[IW-1:0];
            mem_wd   = key_ff;
            count_in = count_ff + CW'(1);
            outc_in  = OUTC_INSERTED;
            state_in = ST_DONE;
         end

         // Load the response register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_outcome_in  = outc_ff;
               rsp_position_in = pos_wide[OUT_W-1:0];
               rsp_entries_in  = cnt_wide[OUT_W-1:0];
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entries_now = rsp_entries_ff;

endmodule
